[rtl/core/u8dec_pkg.sv]
`default_nettype none

package u8dec_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

    // lead and continuation byte bounds
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD_MIN   = 8'hC2;
    localparam logic [7:0] LEAD_3B    = 8'hE0;
    localparam logic [7:0] LEAD_4B    = 8'hF0;
    localparam logic [7:0] LEAD_LIMIT = 8'hF5;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] CONT_A0    = 8'hA0;
    localparam logic [7:0] CONT_90    = 8'h90;

    localparam logic [CP_W-1:0] MIN_2B    = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3B    = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4B    = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_MASK = 21'h1FF800;
    localparam logic [CP_W-1:0] SURR_BASE = 21'h00D800;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            repl;
    } result_t;

    // results caused by one byte; a one-result byte uses first only
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
        logic    fin;
    } rec_t;

endpackage

`default_nettype wire

[rtl/core/u8dec_front.sv]
`default_nettype none

module u8dec_front
    import u8dec_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      data_byte,
    input  wire logic            final_byte,
    input  wire logic            cfg_we,
    input  wire logic [CP_W-1:0] cfg_data,
    output logic                 rec_valid,
    output rec_t                 rec
);

    logic [CP_W-1:0] repl_reg, repl_next;
    logic [7:0]      lead_reg, lead_next;
    logic [1:0]      seen_reg, seen_next;
    logic [14:0]     part_reg, part_next;

    logic            is_cont, first_ok, ok, bad, as_lead;
    logic [1:0]      need, seen_inc;
    logic [CP_W-1:0] acc;
    logic            a_valid, b_valid;
    result_t         a_res, b_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg <= REPL_RESET;
            lead_reg <= '0;
            seen_reg <= '0;
            part_reg <= '0;
        end
        else
        begin
            repl_reg <= repl_next;
            lead_reg <= lead_next;
            seen_reg <= seen_next;
            part_reg <= part_next;
        end
    end

    assign repl_next = cfg_we ? cfg_data : repl_reg;

    always_comb
    begin
        is_cont  = (data_byte & CONT_MASK) == CONT_TAG;
        first_ok = 1'b1;
        if (lead_reg == LEAD_3B && data_byte < CONT_A0) first_ok = 1'b0;
        if (lead_reg == LEAD_ED && data_byte >= CONT_A0) first_ok = 1'b0;
        if (lead_reg == LEAD_4B && data_byte < CONT_90) first_ok = 1'b0;
        if (lead_reg == LEAD_F4 && data_byte >= CONT_90) first_ok = 1'b0;
        ok = is_cont && (seen_reg != 2'd0 || first_ok);

        if (lead_reg < LEAD_3B)      need = 2'd1;
        else if (lead_reg < LEAD_4B) need = 2'd2;
        else                         need = 2'd3;

        acc      = {part_reg, data_byte[5:0]};
        seen_inc = seen_reg + 2'd1;

        unique case (need)
            2'd1:    bad = acc < MIN_2B;
            2'd2:    bad = (acc < MIN_3B) || ((acc & SURR_MASK) == SURR_BASE);
            default: bad = (acc < MIN_4B) || (acc > CP_MAX);
        endcase

        lead_next = lead_reg;
        seen_next = seen_reg;
        part_next = part_reg;
        a_valid   = 1'b0;
        a_res     = '{cp: repl_reg, repl: 1'b1};
        b_valid   = 1'b0;
        b_res     = '{cp: repl_reg, repl: 1'b1};
        as_lead   = 1'b1;

        if (accept)
        begin
            // continuation of an open sequence
            if (lead_reg != 8'd0)
            begin
                if (ok)
                begin
                    seen_next = seen_inc;
                    as_lead   = 1'b0;
                    if (seen_inc >= need)
                    begin
                        a_valid = 1'b1;
                        if (!bad) a_res = '{cp: acc, repl: 1'b0};
                        lead_next = '0;
                        seen_next = '0;
                        part_next = '0;
                    end
                    else if (final_byte)
                    begin
                        a_valid   = 1'b1;
                        lead_next = '0;
                        seen_next = '0;
                        part_next = '0;
                    end
                    else
                    begin
                        part_next = acc[14:0];
                    end
                end
                else
                begin
                    // broken prefix: one replacement, then decode as lead
                    a_valid   = 1'b1;
                    lead_next = '0;
                    seen_next = '0;
                    part_next = '0;
                end
            end

            if (as_lead)
            begin
                if (data_byte < CONT_TAG)
                begin
                    b_valid = 1'b1;
                    b_res   = '{cp: {13'd0, data_byte}, repl: 1'b0};
                end
                else if (data_byte < LEAD_MIN || data_byte >= LEAD_LIMIT || final_byte)
                begin
                    b_valid = 1'b1;
                end
                else
                begin
                    lead_next = data_byte;
                    seen_next = '0;
                    if (data_byte < LEAD_3B)      part_next = {10'd0, data_byte[4:0]};
                    else if (data_byte < LEAD_4B) part_next = {11'd0, data_byte[3:0]};
                    else                          part_next = {12'd0, data_byte[2:0]};
                end
            end
        end

        rec_valid  = a_valid || b_valid;
        rec.two    = a_valid && b_valid;
        rec.first  = a_valid ? a_res : b_res;
        rec.second = b_res;
        rec.fin    = final_byte;
    end

endmodule

`default_nettype wire

[rtl/core/u8dec_queue.sv]
`default_nettype none

module u8dec_queue
    import u8dec_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire rec_t wr_data,
    input  wire logic rd_en,
    output rec_t      rd_data,
    output logic      q_full,
    output logic      q_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rec_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign q_full  = cnt_reg == CNT_FULL;
    assign q_empty = cnt_reg == '0;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)      cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/u8dec_back.sv]
`default_nettype none

module u8dec_back
    import u8dec_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire rec_t       head,
    input  wire logic       q_empty,
    output logic            q_pop,
    input  wire logic       pop,
    output logic            empty,
    output logic [CP_W-1:0] code_point,
    output logic            was_replaced,
    output logic            last_of_run,
    output logic            end_of_text
);

    logic    out_valid_reg, out_valid_next;
    logic    phase_reg, phase_next;
    result_t out_res_reg, out_res_next;
    logic    out_last_reg, out_last_next;
    logic    out_eot_reg, out_eot_next;
    logic    load;

    always_comb
    begin
        load           = !out_valid_reg || pop;
        out_valid_next = out_valid_reg && !pop;
        phase_next     = phase_reg;
        out_res_next   = out_res_reg;
        out_last_next  = out_last_reg;
        out_eot_next   = out_eot_reg;
        q_pop          = 1'b0;
        if (load && !q_empty)
        begin
            out_valid_next = 1'b1;
            if (head.two && !phase_reg)
            begin
                // first half of a pair; record stays at the head
                out_res_next  = head.first;
                out_last_next = 1'b0;
                out_eot_next  = 1'b0;
                phase_next    = 1'b1;
            end
            else
            begin
                out_res_next  = phase_reg ? head.second : head.first;
                out_last_next = 1'b1;
                out_eot_next  = head.fin;
                phase_next    = 1'b0;
                q_pop         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
        out_eot_reg  <= out_eot_next;
    end

    assign empty        = !out_valid_reg;
    assign code_point   = out_res_reg.cp;
    assign was_replaced = out_res_reg.repl;
    assign last_of_run  = out_last_reg;
    assign end_of_text  = out_eot_reg;

    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> !q_empty)
        else $error("pair half-sent but queue head gone");

    a_phase_out: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (out_valid_reg && !out_last_reg && !out_eot_reg))
        else $error("first of pair not held as non-last result");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (out_valid_reg && out_last_reg))
        else $error("record retired without a last result");

endmodule

`default_nettype wire

[rtl/core/utf8_validating_decoder_unit.sv]
`default_nettype none

// UTF-8 validating decoder with replacement (maximal-subpart rule).
// Input queue side: a byte (data_byte, final_byte) transfers at a clock edge
// with push high and full low. One byte per cycle is taken while the internal
// record queue has room.
// Result queue side: while empty is low the oldest result sits on code_point,
// was_replaced, last_of_run, end_of_text; it transfers on pop with empty low.
// Path: a byte that completes a result is decoded and written to the
// record queue at its transfer edge; the output register then loads it
// from the queue head whenever that register is empty or being popped.
// Throughput: one byte per cycle while the record queue has room; a byte
// that gives two results (broken prefix plus a new lead) keeps its record
// at the queue head until the back end has sent both, and the output
// register gives one result per cycle while pop keeps it free.
// Stalls: when pop stays low the output register holds, the record queue
// (QUEUE_DEPTH entries) fills, and full rises; the decoder state only moves
// on a byte transfer, so no data is lost.
// Reset: rst_n clears the open sequence, the queue and the output, and sets
// the replacement code to U+FFFD. cfg_we writes the replacement code from
// cfg_data; write it only while the block is idle.
module utf8_validating_decoder_unit
    import u8dec_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [7:0]      data_byte,
    input  wire logic            final_byte,
    output logic                 empty,
    input  wire logic            pop,
    output logic [CP_W-1:0]      code_point,
    output logic                 was_replaced,
    output logic                 last_of_run,
    output logic                 end_of_text,
    input  wire logic            cfg_we,
    input  wire logic [CP_W-1:0] cfg_data
);

    logic accept;
    logic rec_valid;
    rec_t rec;
    rec_t head;
    logic q_full, q_empty, q_pop;

    // front transfer: queue must have room for the record this byte may make
    assign full   = q_full;
    assign accept = push && !q_full;

    u8dec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    // bytes that make no result write nothing
    u8dec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_valid),
        .wr_data (rec),
        .rd_en   (q_pop),
        .rd_data (head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // back end splits records into single results
    u8dec_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .code_point   (code_point),
        .was_replaced (was_replaced),
        .last_of_run  (last_of_run),
        .end_of_text  (end_of_text)
    );

endmodule

`default_nettype wire
